// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the quaternion unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every clock edge outside reset
`define QAU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition that must hold in the cycle after a trigger
`define QAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define QAU_ASSERT(label, clk, rst, prop)
`define QAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, opcodes and product tables for the quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none
package qau_pkg;

   localparam int WORD_BITS_DEF   = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int RES_BITS        = 32;
   localparam int CMD_BITS        = 3;

   localparam logic [CMD_BITS-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_MUL   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_SCALE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_DIV   = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_INV   = 3'd5;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_SCALE,
      OP_DIV,
      OP_INV,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Hamilton product: result component c, term t uses lhs[a] * rhs[b]
   function automatic logic [1:0] ham_lhs_idx(input logic [1:0] c, input logic [1:0] t);
      logic [1:0] idx;
      case ({c, t})
         4'h0: idx = 2'd0;  4'h1: idx = 2'd1;  4'h2: idx = 2'd2;  4'h3: idx = 2'd3;
         4'h4: idx = 2'd0;  4'h5: idx = 2'd1;  4'h6: idx = 2'd2;  4'h7: idx = 2'd3;
         4'h8: idx = 2'd0;  4'h9: idx = 2'd2;  4'ha: idx = 2'd3;  4'hb: idx = 2'd1;
         4'hc: idx = 2'd0;  4'hd: idx = 2'd3;  4'he: idx = 2'd1;  4'hf: idx = 2'd2;
         default: idx = 2'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [1:0] ham_rhs_idx(input logic [1:0] c, input logic [1:0] t);
      logic [1:0] idx;
      case ({c, t})
         4'h0: idx = 2'd0;  4'h1: idx = 2'd1;  4'h2: idx = 2'd2;  4'h3: idx = 2'd3;
         4'h4: idx = 2'd1;  4'h5: idx = 2'd0;  4'h6: idx = 2'd3;  4'h7: idx = 2'd2;
         4'h8: idx = 2'd2;  4'h9: idx = 2'd0;  4'ha: idx = 2'd1;  4'hb: idx = 2'd3;
         4'hc: idx = 2'd3;  4'hd: idx = 2'd0;  4'he: idx = 2'd2;  4'hf: idx = 2'd1;
         default: idx = 2'd0;
      endcase
      return idx;
   endfunction

   // real part subtracts three terms, the others subtract only their last term
   function automatic logic ham_neg(input logic [1:0] c, input logic [1:0] t);
      return (c == 2'd0) ? (t != 2'd0) : (t == 2'd3);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Signed fixed-point quaternion unit: add, subtract, Hamilton product, scale,
// divide by scalar and inverse, with saturation and divide-by-zero flags.
// A command is taken at a clock edge where start is high and busy is low; it
// lands in a four-entry queue that feeds a product stage, a sum stage and a
// result register, so add, subtract, multiply, scale and zero-divisor cases
// stream at one per cycle whenever the divider is not holding the pipe.
// Divide and inverse go through one shared radix-2 divider that resolves one
// quotient bit per cycle for all four components and holds the pipe until
// every quotient bit is in (the default word is Q16.16); busy rises only when
// the queue fills behind it. Each result is marked on the rsp_ ports by a
// one-cycle rsp_strobe and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_arithmetic_unit_core
   import qau_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CMD_BITS-1:0]  req_cmd,
   input  wire logic [RES_BITS-1:0]  req_lhs_real,
   input  wire logic [RES_BITS-1:0]  req_lhs_i,
   input  wire logic [RES_BITS-1:0]  req_lhs_j,
   input  wire logic [RES_BITS-1:0]  req_lhs_k,
   input  wire logic [RES_BITS-1:0]  req_rhs_real,
   input  wire logic [RES_BITS-1:0]  req_rhs_i,
   input  wire logic [RES_BITS-1:0]  req_rhs_j,
   input  wire logic [RES_BITS-1:0]  req_rhs_k,
   input  wire logic [RES_BITS-1:0]  req_scalar,
   output logic                      rsp_strobe,
   output logic [RES_BITS-1:0]       rsp_res_real,
   output logic [RES_BITS-1:0]       rsp_res_i,
   output logic [RES_BITS-1:0]       rsp_res_j,
   output logic [RES_BITS-1:0]       rsp_res_k,
   output logic                      rsp_div_by_zero,
   output logic                      rsp_saturated
);

   localparam int OPW        = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int ENTRY_BITS = 3 + 9 * OPW;

   fifo_status_type        queue_status;
   logic                   push;
   logic                   pop;
   logic [ENTRY_BITS-1:0]  push_data;
   logic [ENTRY_BITS-1:0]  head_data;

   qau_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_lhs_real (req_lhs_real),
      .req_lhs_i    (req_lhs_i),
      .req_lhs_j    (req_lhs_j),
      .req_lhs_k    (req_lhs_k),
      .req_rhs_real (req_rhs_real),
      .req_rhs_i    (req_rhs_i),
      .req_rhs_j    (req_rhs_j),
      .req_rhs_k    (req_rhs_k),
      .req_scalar   (req_scalar),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   qau_fifo #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   qau_back #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_res_real    (rsp_res_real),
      .rsp_res_i       (rsp_res_i),
      .rsp_res_j       (rsp_res_j),
      .rsp_res_k       (rsp_res_k),
      .rsp_div_by_zero (rsp_div_by_zero),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
`default_nettype wire

// File: rtl/core/qau_front.sv
// ----------------------------------------------------------------------------
// qau_front
// Accepts commands, decodes the opcode and trims operands to the word width.
// ----------------------------------------------------------------------------
`default_nettype none
module qau_front
   import qau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [CMD_BITS-1:0]       req_cmd,
   input  wire logic [RES_BITS-1:0]       req_lhs_real,
   input  wire logic [RES_BITS-1:0]       req_lhs_i,
   input  wire logic [RES_BITS-1:0]       req_lhs_j,
   input  wire logic [RES_BITS-1:0]       req_lhs_k,
   input  wire logic [RES_BITS-1:0]       req_rhs_real,
   input  wire logic [RES_BITS-1:0]       req_rhs_i,
   input  wire logic [RES_BITS-1:0]       req_rhs_j,
   input  wire logic [RES_BITS-1:0]       req_rhs_k,
   input  wire logic [RES_BITS-1:0]       req_scalar,
   input  wire fifo_status_type           queue_status,
   output logic                           push,
   output logic [3+9*((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] push_data
);

   localparam int OPW = (WORD_BITS < 32) ? WORD_BITS : 32;

   op_type op;

   always_comb begin
      case (req_cmd)
         CMD_ADD:   op = OP_ADD;
         CMD_SUB:   op = OP_SUB;
         CMD_MUL:   op = OP_MUL;
         CMD_SCALE: op = OP_SCALE;
         CMD_DIV:   op = OP_DIV;
         CMD_INV:   op = OP_INV;
         default:   op = OP_NONE;
      endcase
   end

   assign busy = queue_status.full;
   assign push = start & ~queue_status.full;

   // operands keep only their low word; sign extension happens downstream
   assign push_data = {req_scalar[OPW-1:0],
                       req_rhs_k[OPW-1:0], req_rhs_j[OPW-1:0],
                       req_rhs_i[OPW-1:0], req_rhs_real[OPW-1:0],
                       req_lhs_k[OPW-1:0], req_lhs_j[OPW-1:0],
                       req_lhs_i[OPW-1:0], req_lhs_real[OPW-1:0],
                       op};

endmodule
`default_nettype wire

// File: rtl/core/qau_fifo.sv
// ----------------------------------------------------------------------------
// qau_fifo
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
`default_nettype none
module qau_fifo
   import qau_pkg::*;
#(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      head_data,
   output fifo_status_type           status
);
`include "assert_macros.svh"

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

   `QAU_ASSERT(a_count_range, clock, reset, count_ff <= CNT_BITS'(DEPTH))
   `QAU_ASSERT(a_pop_nonempty, clock, reset, pop |-> !status.empty)
   `QAU_ASSERT(a_push_room, clock, reset, push |-> (!status.full || pop))

endmodule
`default_nettype wire

// File: rtl/core/qau_back.sv
// ----------------------------------------------------------------------------
// qau_back
// Execution pipeline: products, sums, rounding and saturation, plus a shared
// radix-2 divider for divide and inverse.
// ----------------------------------------------------------------------------
`default_nettype none
module qau_back
   import qau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fifo_status_type       queue_status,
   input  wire logic [3+9*((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] head_data,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [RES_BITS-1:0]        rsp_res_real,
   output logic [RES_BITS-1:0]        rsp_res_i,
   output logic [RES_BITS-1:0]        rsp_res_j,
   output logic [RES_BITS-1:0]        rsp_res_k,
   output logic                       rsp_div_by_zero,
   output logic                       rsp_saturated
);
`include "assert_macros.svh"

   localparam int OPW       = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int PROD_BITS = 2 * OPW;
   localparam int ACC_BITS  = 2 * OPW + 2;
   localparam int DEN_BITS  = 2 * OPW + 1;
   localparam int NUM_A     = OPW + 2 * FRAC_BITS;
   localparam int NUM_B     = 2 * OPW;
   localparam int NUM_BITS  = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
   localparam int QUO_BITS  = NUM_BITS + 1;
   localparam int SAT_A     = (QUO_BITS > ACC_BITS + 1) ? QUO_BITS : ACC_BITS + 1;
   localparam int SAT_BITS  = ((SAT_A > WORD_BITS) ? SAT_A : WORD_BITS) + 1;
   localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

   localparam logic signed [SAT_BITS-1:0] SAT_MAX =
      (SAT_BITS'(1) <<< (WORD_BITS - 1)) - SAT_BITS'(1);
   localparam logic signed [SAT_BITS-1:0] SAT_MIN = -(SAT_BITS'(1) <<< (WORD_BITS - 1));
   localparam logic signed [SAT_BITS-1:0] HALF    = SAT_BITS'(1) <<< (FRAC_BITS - 1);

   // clip to the word range; low result bits carry the sign-extended word
   function automatic logic [RES_BITS:0] sat_word(input logic signed [SAT_BITS-1:0] v);
      logic [RES_BITS:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, SAT_MAX[RES_BITS-1:0]};
      end else if (v < SAT_MIN) begin
         r = {1'b1, SAT_MIN[RES_BITS-1:0]};
      end else begin
         r = {1'b0, v[RES_BITS-1:0]};
      end
      return r;
   endfunction

   // ---------------- head decode ----------------
   op_type                  head_op;
   logic signed [OPW-1:0]   l_w [4];
   logic signed [OPW-1:0]   r_w [4];
   logic signed [OPW-1:0]   s_w;
   logic                    adv;
   logic                    div_busy_ff, div_busy_in;

   assign head_op = op_type'(head_data[2:0]);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         l_w[c] = head_data[3 + c * OPW +: OPW];
         r_w[c] = head_data[3 + (4 + c) * OPW +: OPW];
      end
      s_w = head_data[3 + 8 * OPW +: OPW];
   end

   // ---------------- stage 1: products ----------------
   logic                          s1_valid_ff, s1_valid_in;
   op_type                        s1_op_ff;
   logic signed [PROD_BITS-1:0]   p_ff [16];
   logic signed [PROD_BITS-1:0]   p_in [16];
   logic signed [OPW-1:0]         ma_w [16];
   logic signed [OPW-1:0]         mb_w [16];
   logic signed [OPW:0]           as_ff [4];
   logic signed [OPW:0]           as_in [4];
   logic [OPW-1:0]                lmag_ff [4];
   logic [OPW-1:0]                lmag_in [4];
   logic                          lneg_ff [4];
   logic [OPW-1:0]                smag_ff, smag_in;
   logic                          sneg_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int t = 0; t < 4; t++) begin
            ma_w[4 * c + t] = '0;
            mb_w[4 * c + t] = '0;
            case (head_op)
               OP_MUL: begin
                  ma_w[4 * c + t] = l_w[ham_lhs_idx(2'(c), 2'(t))];
                  mb_w[4 * c + t] = r_w[ham_rhs_idx(2'(c), 2'(t))];
               end
               OP_SCALE: begin
                  if (t == 0) begin
                     ma_w[4 * c + t] = l_w[c];
                     mb_w[4 * c + t] = s_w;
                  end
               end
               OP_INV: begin
                  // squares of the left operand sum in row zero
                  if (c == 0) begin
                     ma_w[4 * c + t] = l_w[t];
                     mb_w[4 * c + t] = l_w[t];
                  end
               end
               default: begin
                  ma_w[4 * c + t] = '0;
               end
            endcase
            p_in[4 * c + t] = ma_w[4 * c + t] * mb_w[4 * c + t];
         end
         as_in[c]   = (head_op == OP_SUB) ? ((OPW + 1)'(l_w[c]) - (OPW + 1)'(r_w[c]))
                                          : ((OPW + 1)'(l_w[c]) + (OPW + 1)'(r_w[c]));
         lmag_in[c] = l_w[c][OPW-1] ? (~l_w[c] + 1'b1) : l_w[c];
      end
      smag_in = s_w[OPW-1] ? (~s_w + 1'b1) : s_w;
   end

   assign adv         = ~div_busy_ff;
   assign pop         = ~queue_status.empty & adv;
   assign s1_valid_in = adv ? ~queue_status.empty : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff <= head_op;
         for (int k = 0; k < 16; k++) begin
            p_ff[k] <= p_in[k];
         end
         for (int c = 0; c < 4; c++) begin
            as_ff[c]   <= as_in[c];
            lmag_ff[c] <= lmag_in[c];
            lneg_ff[c] <= l_w[c][OPW-1];
         end
         smag_ff <= smag_in;
         sneg_ff <= s_w[OPW-1];
      end
   end

   // ---------------- stage 2: sums ----------------
   logic                          s2_valid_ff, s2_valid_in;
   op_type                        s2_op_ff;
   logic signed [ACC_BITS-1:0]    acc_ff [4];
   logic signed [ACC_BITS-1:0]    acc_in [4];
   logic [OPW-1:0]                lmag2_ff [4];
   logic                          lneg2_ff [4];
   logic [OPW-1:0]                smag2_ff;
   logic                          sneg2_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         acc_in[c] = '0;
         case (s1_op_ff)
            OP_ADD, OP_SUB: begin
               acc_in[c] = ACC_BITS'(as_ff[c]);
            end
            OP_MUL: begin
               for (int t = 0; t < 4; t++) begin
                  if (ham_neg(2'(c), 2'(t))) begin
                     acc_in[c] = acc_in[c] - ACC_BITS'(p_ff[4 * c + t]);
                  end else begin
                     acc_in[c] = acc_in[c] + ACC_BITS'(p_ff[4 * c + t]);
                  end
               end
            end
            OP_SCALE, OP_INV: begin
               for (int t = 0; t < 4; t++) begin
                  acc_in[c] = acc_in[c] + ACC_BITS'(p_ff[4 * c + t]);
               end
            end
            default: begin
               acc_in[c] = '0;
            end
         endcase
      end
   end

   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff <= s1_op_ff;
         for (int c = 0; c < 4; c++) begin
            acc_ff[c]   <= acc_in[c];
            lmag2_ff[c] <= lmag_ff[c];
            lneg2_ff[c] <= lneg_ff[c];
         end
         smag2_ff <= smag_ff;
         sneg2_ff <= sneg_ff;
      end
   end

   // ---------------- divider ----------------
   logic [CNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic [DEN_BITS-1:0]    dden_ff, dden_in;
   logic [NUM_BITS-1:0]    dnum_ff [4];
   logic [NUM_BITS-1:0]    dnum_in [4];
   logic [DEN_BITS-1:0]    drem_ff [4];
   logic [DEN_BITS-1:0]    drem_in [4];
   logic [NUM_BITS-1:0]    dquo_ff [4];
   logic [NUM_BITS-1:0]    dquo_in [4];
   logic                   dneg_ff [4];
   logic                   dneg_in [4];
   logic [DEN_BITS:0]      rem_sh [4];
   logic                   div_done;
   logic                   div_launch;
   logic                   launch_dz;
   logic                   s2_is_div;

   assign s2_is_div = (s2_op_ff == OP_DIV) || (s2_op_ff == OP_INV);
   assign dden_in   = (s2_op_ff == OP_DIV) ? DEN_BITS'(smag2_ff) : acc_ff[0][DEN_BITS-1:0];
   assign launch_dz = (dden_in == '0);
   assign div_launch = adv & s2_valid_ff & s2_is_div & ~launch_dz;
   assign div_done   = div_busy_ff & (div_cnt_ff == CNT_BITS'(NUM_BITS));

   always_comb begin
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      for (int c = 0; c < 4; c++) begin
         rem_sh[c]  = {drem_ff[c], dnum_ff[c][NUM_BITS-1]};
         dnum_in[c] = dnum_ff[c];
         drem_in[c] = drem_ff[c];
         dquo_in[c] = dquo_ff[c];
         dneg_in[c] = dneg_ff[c];
      end
      if (div_launch) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         for (int c = 0; c < 4; c++) begin
            drem_in[c] = '0;
            dquo_in[c] = '0;
            if (s2_op_ff == OP_DIV) begin
               dnum_in[c] = (NUM_BITS'(lmag2_ff[c]) << FRAC_BITS)
                          + NUM_BITS'(smag2_ff >> 1);
               dneg_in[c] = lneg2_ff[c] ^ sneg2_ff;
            end else begin
               dnum_in[c] = (NUM_BITS'(lmag2_ff[c]) << (2 * FRAC_BITS))
                          + NUM_BITS'(dden_in >> 1);
               // conjugate: vector parts flip sign
               dneg_in[c] = (c == 0) ? lneg2_ff[c]
                                     : (~lneg2_ff[c] & (lmag2_ff[c] != '0));
            end
         end
      end else if (div_done) begin
         div_busy_in = 1'b0;
      end else if (div_busy_ff) begin
         div_cnt_in = div_cnt_ff + 1'b1;
         for (int c = 0; c < 4; c++) begin
            dnum_in[c] = {dnum_ff[c][NUM_BITS-2:0], 1'b0};
            if (rem_sh[c] >= {1'b0, dden_ff}) begin
               drem_in[c] = DEN_BITS'(rem_sh[c] - {1'b0, dden_ff});
               dquo_in[c] = {dquo_ff[c][NUM_BITS-2:0], 1'b1};
            end else begin
               drem_in[c] = rem_sh[c][DEN_BITS-1:0];
               dquo_in[c] = {dquo_ff[c][NUM_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         div_busy_ff <= div_busy_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_launch) begin
         dden_ff <= dden_in;
      end
      for (int c = 0; c < 4; c++) begin
         dnum_ff[c] <= dnum_in[c];
         drem_ff[c] <= drem_in[c];
         dquo_ff[c] <= dquo_in[c];
         dneg_ff[c] <= dneg_in[c];
      end
   end

   // ---------------- result register ----------------
   logic                        strobe_ff, strobe_in;
   logic [RES_BITS-1:0]         res_ff [4];
   logic [RES_BITS-1:0]         res_in [4];
   logic                        dz_ff, dz_in;
   logic                        sat_ff, sat_in;
   logic signed [SAT_BITS-1:0]  val_w [4];
   logic [RES_BITS:0]           clip_w [4];

   always_comb begin
      strobe_in = 1'b0;
      dz_in     = dz_ff;
      sat_in    = sat_ff;
      for (int c = 0; c < 4; c++) begin
         res_in[c] = res_ff[c];
         if (div_done) begin
            val_w[c] = dneg_ff[c] ? -SAT_BITS'(dquo_ff[c]) : SAT_BITS'(dquo_ff[c]);
         end else if ((s2_op_ff == OP_ADD) || (s2_op_ff == OP_SUB)) begin
            val_w[c] = SAT_BITS'(acc_ff[c]);
         end else begin
            val_w[c] = (SAT_BITS'(acc_ff[c]) + HALF) >>> FRAC_BITS;
         end
         clip_w[c] = sat_word(val_w[c]);
      end
      if (div_done) begin
         strobe_in = 1'b1;
         dz_in     = 1'b0;
         sat_in    = clip_w[0][RES_BITS] | clip_w[1][RES_BITS]
                   | clip_w[2][RES_BITS] | clip_w[3][RES_BITS];
         for (int c = 0; c < 4; c++) begin
            res_in[c] = clip_w[c][RES_BITS-1:0];
         end
      end else if (adv && s2_valid_ff) begin
         case (s2_op_ff)
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE: begin
               strobe_in = 1'b1;
               dz_in     = 1'b0;
               sat_in    = clip_w[0][RES_BITS] | clip_w[1][RES_BITS]
                         | clip_w[2][RES_BITS] | clip_w[3][RES_BITS];
               for (int c = 0; c < 4; c++) begin
                  res_in[c] = clip_w[c][RES_BITS-1:0];
               end
            end
            OP_DIV, OP_INV: begin
               // zero divisor answers at once; otherwise the divider takes over
               if (launch_dz) begin
                  strobe_in = 1'b1;
                  dz_in     = 1'b1;
                  sat_in    = 1'b0;
                  for (int c = 0; c < 4; c++) begin
                     res_in[c] = '0;
                  end
               end
            end
            default: begin
               strobe_in = 1'b1;
               dz_in     = 1'b0;
               sat_in    = 1'b0;
               for (int c = 0; c < 4; c++) begin
                  res_in[c] = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dz_ff  <= dz_in;
      sat_ff <= sat_in;
      for (int c = 0; c < 4; c++) begin
         res_ff[c] <= res_in[c];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_res_real    = res_ff[0];
   assign rsp_res_i       = res_ff[1];
   assign rsp_res_j       = res_ff[2];
   assign rsp_res_k       = res_ff[3];
   assign rsp_div_by_zero = dz_ff;
   assign rsp_saturated   = sat_ff;

   `QAU_ASSERT(a_cnt_range, clock, reset, div_busy_ff |-> (div_cnt_ff <= CNT_BITS'(NUM_BITS)))
   `QAU_ASSERT_NEXT(a_quiet_while_dividing, clock, reset, div_busy_ff && !div_done, !strobe_ff)
   `QAU_ASSERT(a_dz_zero_result, clock, reset, (strobe_ff && dz_ff) |-> (!sat_ff && res_ff[0] == '0 && res_ff[1] == '0 && res_ff[2] == '0 && res_ff[3] == '0))
   `QAU_ASSERT_NEXT(a_launch_busy, clock, reset, div_launch, div_busy_ff && !strobe_ff)

endmodule
`default_nettype wire

// File: tb/tb_quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_arithmetic_unit_core
// Self-checking bench for the quaternion unit: a queue-fed driver issues
// commands under random sender gaps, a monitor compares every strobed result
// word against an in-bench fixed-point model of each operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_quaternion_arithmetic_unit_core;
   import qau_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_NONE  = OP_NONE;
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic signed [127:0] WORD_MAX = 128'sd2147483647;
   localparam logic signed [127:0] WORD_MIN = -128'sd2147483648;

   typedef struct {
      logic [CMD_BITS-1:0] cmd;
      logic signed [31:0]  lhs [4];
      logic signed [31:0]  rhs [4];
      logic signed [31:0]  scalar;
   } quat_cmd_type;

   typedef struct {
      logic [31:0] comp [4];
      logic        div_by_zero;
      logic        saturated;
   } quat_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_BITS-1:0] req_cmd = '0;
   logic [31:0] req_lhs [4] = '{default: '0};
   logic [31:0] req_rhs [4] = '{default: '0};
   logic [31:0] req_scalar = '0;
   logic rsp_strobe, rsp_div_by_zero, rsp_saturated;
   logic [31:0] rsp_res [4];

   quat_cmd_type pending_cmds [$];
   quat_res_type expected_results [$];
   int  idle_pct = 0;
   int  idle_pct_by_phase [3] = '{23, 82, 0};
   bit  hold_off = 1'b0;
   int  errors = 0;
   int  cycles = 0;

   quaternion_arithmetic_unit_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd),
      .req_lhs_real(req_lhs[0]), .req_lhs_i(req_lhs[1]),
      .req_lhs_j(req_lhs[2]), .req_lhs_k(req_lhs[3]),
      .req_rhs_real(req_rhs[0]), .req_rhs_i(req_rhs[1]),
      .req_rhs_j(req_rhs[2]), .req_rhs_k(req_rhs[3]),
      .req_scalar(req_scalar),
      .rsp_strobe(rsp_strobe),
      .rsp_res_real(rsp_res[0]), .rsp_res_i(rsp_res[1]),
      .rsp_res_j(rsp_res[2]), .rsp_res_k(rsp_res[3]),
      .rsp_div_by_zero(rsp_div_by_zero), .rsp_saturated(rsp_saturated)
   );

   always #5 clock = ~clock;

   function automatic logic [127:0] magnitude(input logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // round to nearest, halves away from zero (on magnitudes)
   function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [127:0] d);
      return (n + (d >> 1)) / d;
   endfunction

   function automatic logic signed [127:0] round_product(input logic signed [127:0] v);
      return (v + 128'sd32768) >>> 16;
   endfunction

   function automatic quat_res_type quat_compute(input quat_cmd_type c);
      logic signed [127:0] a [4];
      logic signed [127:0] b [4];
      logic signed [127:0] s, sq;
      logic signed [127:0] v [4];
      logic [127:0] q;
      logic neg;
      quat_res_type r;
      for (int n = 0; n < 4; n++) begin
         a[n] = c.lhs[n];
         b[n] = c.rhs[n];
         v[n] = '0;
      end
      s = c.scalar;
      r.div_by_zero = 1'b0;
      r.saturated = 1'b0;
      case (c.cmd)
         CMD_ADD: for (int n = 0; n < 4; n++) v[n] = a[n] + b[n];
         CMD_SUB: for (int n = 0; n < 4; n++) v[n] = a[n] - b[n];
         CMD_MUL: begin
            v[0] = round_product(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
            v[1] = round_product(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
            v[2] = round_product(a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3]);
            v[3] = round_product(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]);
         end
         CMD_SCALE: for (int n = 0; n < 4; n++) v[n] = round_product(a[n] * s);
         CMD_DIV: begin
            if (s == 0) r.div_by_zero = 1'b1;
            else for (int n = 0; n < 4; n++) begin
               q = div_nearest(magnitude(a[n]) << 16, magnitude(s));
               v[n] = ((a[n] < 0) != (s < 0)) ? -$signed(q) : $signed(q);
            end
         end
         CMD_INV: begin
            sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
            if (sq == 0) r.div_by_zero = 1'b1;
            else for (int n = 0; n < 4; n++) begin
               q = div_nearest(magnitude(a[n]) << 32, sq);
               neg = (n == 0) ? (a[n] < 0) : (a[n] > 0);
               v[n] = neg ? -$signed(q) : $signed(q);
            end
         end
         default: ;
      endcase
      for (int n = 0; n < 4; n++) begin
         if (v[n] > WORD_MAX) begin
            v[n] = WORD_MAX;
            r.saturated = 1'b1;
         end else if (v[n] < WORD_MIN) begin
            v[n] = WORD_MIN;
            r.saturated = 1'b1;
         end
         r.comp[n] = v[n][31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sd0;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return 32'sd65536;
         4: return -32'sd1;
         5: return $signed($urandom_range(0, 16'hffff)) - 32'sd32768;
         6: return $signed($urandom_range(0, 32'h7ffff)) - 32'sd262144;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic quat_cmd_type random_cmd();
      quat_cmd_type c;
      c.cmd = ($urandom_range(0, 19) == 0) ? CMD_BITS'($urandom_range(6, 7))
                                           : CMD_BITS'($urandom_range(0, 5));
      for (int n = 0; n < 4; n++) begin
         c.lhs[n] = pick_value();
         c.rhs[n] = pick_value();
      end
      c.scalar = pick_value();
      return c;
   endfunction

   function automatic quat_cmd_type fill_cmd(input logic [CMD_BITS-1:0] op,
                                             input logic signed [31:0] lv,
                                             input logic signed [31:0] rv,
                                             input logic signed [31:0] sv);
      quat_cmd_type c;
      c.cmd = op;
      for (int n = 0; n < 4; n++) begin
         c.lhs[n] = lv;
         c.rhs[n] = rv;
      end
      c.scalar = sv;
      return c;
   endfunction

   // driver: present the head word at the falling edge unless idling
   always @(negedge clock) begin
      quat_cmd_type c;
      if (!reset && !hold_off && pending_cmds.size() != 0
          && $urandom_range(0, 99) >= idle_pct) begin
         c = pending_cmds[0];
         start <= 1'b1;
         req_cmd <= c.cmd;
         for (int n = 0; n < 4; n++) begin
            req_lhs[n] <= c.lhs[n];
            req_rhs[n] <= c.rhs[n];
         end
         req_scalar <= c.scalar;
      end else begin
         start <= 1'b0;
      end
   end

   // acceptance and result checking
   always @(posedge clock) begin
      quat_res_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && start && !busy) begin
         expected_results.push_back(quat_compute(pending_cmds[0]));
         void'(pending_cmds.pop_front());
      end
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word real=%h", $time, rsp_res[0]);
            errors++;
         end else begin
            e = expected_results.pop_front();
            for (int n = 0; n < 4; n++)
               if (rsp_res[n] !== e.comp[n]) begin
                  $display("%0t: component %0d expected %h actual %h",
                           $time, n, e.comp[n], rsp_res[n]);
                  errors++;
               end
            if (rsp_div_by_zero !== e.div_by_zero) begin
               $display("%0t: div_by_zero expected %b actual %b",
                        $time, e.div_by_zero, rsp_div_by_zero);
               errors++;
            end
            if (rsp_saturated !== e.saturated) begin
               $display("%0t: saturated expected %b actual %b",
                        $time, e.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      quat_cmd_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every operation, zero divisor, unused opcodes
      pending_cmds.push_back(fill_cmd(CMD_ADD, 32'sh7fffffff, 32'sh7fffffff, 0));
      pending_cmds.push_back(fill_cmd(CMD_ADD, 32'sh80000000, 32'sh80000000, 0));
      pending_cmds.push_back(fill_cmd(CMD_SUB, 32'sh80000000, 32'sh7fffffff, 0));
      pending_cmds.push_back(fill_cmd(CMD_SUB, 32'sh7fffffff, 32'sh80000000, 0));
      pending_cmds.push_back(fill_cmd(CMD_SUB, 32'sd5, 32'sd5, 0));
      pending_cmds.push_back(fill_cmd(CMD_MUL, 32'sh80000000, 32'sh80000000, 0));
      pending_cmds.push_back(fill_cmd(CMD_MUL, 32'sd65536, 32'sd98304, 0));
      pending_cmds.push_back(fill_cmd(CMD_MUL, 32'sd1, 32'sd32768, 0));
      pending_cmds.push_back(fill_cmd(CMD_MUL, -32'sd1, 32'sd32768, 0));
      pending_cmds.push_back(fill_cmd(CMD_SCALE, 32'sh7fffffff, 0, 32'sh80000000));
      pending_cmds.push_back(fill_cmd(CMD_SCALE, 32'sd3, 0, 32'sd32768));
      pending_cmds.push_back(fill_cmd(CMD_SCALE, -32'sd3, 0, 32'sd32768));
      pending_cmds.push_back(fill_cmd(CMD_DIV, 32'sd65536, 0, 32'sd0));
      pending_cmds.push_back(fill_cmd(CMD_DIV, 32'sh7fffffff, 0, 32'sd1));
      pending_cmds.push_back(fill_cmd(CMD_DIV, 32'sh80000000, 0, 32'sh80000000));
      pending_cmds.push_back(fill_cmd(CMD_DIV, -32'sd1, 0, 32'sd131072));
      pending_cmds.push_back(fill_cmd(CMD_INV, 32'sd0, 0, 0));
      pending_cmds.push_back(fill_cmd(CMD_INV, 32'sd65536, 0, 0));
      pending_cmds.push_back(fill_cmd(CMD_INV, 32'sh80000000, 0, 0));
      pending_cmds.push_back(fill_cmd(CMD_INV, 32'sd1, 0, 0));
      pending_cmds.push_back(fill_cmd(CMD_NONE, 32'sh7fffffff, 32'sh7fffffff, -32'sd1));
      pending_cmds.push_back(fill_cmd(CMD_SPARE, -32'sd1, -32'sd1, -32'sd1));
      c = fill_cmd(CMD_INV, 0, 0, 0);
      c.lhs[0] = -32'sd65536;
      c.lhs[2] = 32'sd65536;
      pending_cmds.push_back(c);
      // wait until every directed word has come back, then pause the sender
      drain();
      hold_off = 1'b1;
      repeat (5) @(posedge clock);
      hold_off = 1'b0;
      foreach (idle_pct_by_phase[p]) begin
         idle_pct = idle_pct_by_phase[p];
         repeat (145) pending_cmds.push_back(random_cmd());
         drain();
      end
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
